/* sv/fla_pkg.sv */
// Shared types, codes and constants of the free list fit allocator.
package fla_pkg;

  localparam int ADDR_BITS     = 32;
  localparam int SIZE_W        = 32;
  localparam int NEED_W        = 25;
  localparam int OFFS_W        = 12;
  localparam int ALIGN_W       = 13;
  localparam int POOL_W        = 25;
  localparam int GUARD_BYTES   = 4;
  localparam int MAX_ALIGN_LG  = 12;
  localparam int MAX_CODE      = 13;
  localparam int POOL_MAX      = 16777216;
  localparam int POOL_SIZE_RST = 65536;
  localparam int DALIGN_RST    = 4;
  localparam int CFG_W         = 32;
  localparam int CFG_IDX_W     = 2;

  localparam int GRANT_ENTRIES_DEF = 16;
  localparam int FREE_ENTRIES_DEF  = 17;

  localparam int FREE_ENTRY_W  = ADDR_BITS + SIZE_W;
  localparam int GRANT_ENTRY_W = ADDR_BITS + NEED_W + OFFS_W;

  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NOFIT   = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;
  localparam logic [1:0] STAT_UNKNOWN = 2'd3;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DALIGN     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE  = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_NEED, S_FIT, S_ALIGN, S_COMMIT, S_FSHIFT,
    S_GSCAN, S_GPREP, S_GEND, S_GSHIFT, S_NSCAN, S_MERGE, S_OUT
  } state_t;

endpackage

/* sv/fla_req_if.sv */
// Request channel of the allocator.
interface fla_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [23:0] alloc_size;
  logic [3:0]  align_code;
  logic [31:0] free_address;

  modport source (output valid, req_type, alloc_size, align_code, free_address,
                  input ready);
  modport sink (input valid, req_type, alloc_size, align_code, free_address,
                output ready);
endinterface

/* sv/fla_rsp_if.sv */
// Response channel of the allocator.
interface fla_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] granted_address;
  logic [1:0]  status;

  modport source (output valid, granted_address, status, input ready);
  modport sink (input valid, granted_address, status, output ready);
endinterface

/* sv/fla_ram.sv */
// Generic single write port RAM with a registered read port.
module fla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* sv/free_list_fit_allocator.sv */
// Top level of the free list fit allocator: sequencer, registers and table RAMs.
//
// The allocator hands out blocks of one address pool from an ordered free table
// and records every grant in a grant table; both tables sit in single-port-write
// RAMs with a registered read, and one small sequencer walks them one entry per
// cycle. A request is taken only while the sequencer is idle, and exactly one
// response beat comes back per request. An allocate that uses an entry up also
// walks the entries behind it to close the gap, and one that meets a full grant
// table goes straight to its response. A free runs the grant search and, when it
// finds the address, the grant table compaction, the neighbor search and, when it
// joins two free entries, the free table compaction. A response that the receiver
// does not take holds the sequencer before it returns to idle. Writing pool_base
// or pool_size reloads the free table with the whole pool in the same cycle; the
// grant table is kept. Configuration is to be written only while idle; the block
// itself does not enforce it.
module free_list_fit_allocator #(
  parameter int GRANT_ENTRIES = fla_pkg::GRANT_ENTRIES_DEF,
  parameter int FREE_ENTRIES  = fla_pkg::FREE_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  fla_req_if.sink                       req,
  fla_rsp_if.source                     rsp,
  input  logic                          cfg_we,
  input  logic [fla_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fla_pkg::CFG_W-1:0]     cfg_data
);

  localparam int FC_W = $clog2(FREE_ENTRIES + 1);
  localparam int GC_W = $clog2(GRANT_ENTRIES + 1);
  localparam int FI_W = (FREE_ENTRIES > 1) ? $clog2(FREE_ENTRIES) : 1;
  localparam int GI_W = (GRANT_ENTRIES > 1) ? $clog2(GRANT_ENTRIES) : 1;
  localparam int CW   = (FC_W > GC_W) ? FC_W : GC_W;
  localparam int AW   = fla_pkg::ADDR_BITS;
  localparam int SW   = fla_pkg::SIZE_W;
  localparam int NW   = fla_pkg::NEED_W;
  localparam int OW   = fla_pkg::OFFS_W;
  localparam int LW   = fla_pkg::ALIGN_W;

  fla_pkg::state_t state, state_next;

  // Configuration registers and table occupancy.
  logic [1:0]              fit_policy;
  logic [3:0]              dalign;
  logic [AW-1:0]           pool_base;
  logic [fla_pkg::POOL_W-1:0] pool_size;
  logic [FC_W-1:0]         free_count, free_count_next;
  logic [GC_W-1:0]         grant_count, grant_count_next;

  // Request capture and working registers.
  logic [AW-1:0]           r_addr, r_addr_next;
  logic [23:0]             r_size, r_size_next;
  logic [3:0]              lg, lg_next;
  logic [LW-1:0]           align, align_next;
  logic [NW-1:0]           need, need_next;
  logic [OW-1:0]           offs, offs_next;
  logic [CW-1:0]           cnt, cnt_next;
  logic                    ev_valid, ev_valid_next;
  logic [CW-1:0]           ev_idx, ev_idx_next;
  logic                    found, found_next;
  logic [CW-1:0]           pick_idx, pick_idx_next;
  logic [AW-1:0]           pick_base, pick_base_next;
  logic [SW-1:0]           pick_size, pick_size_next;
  logic [AW-1:0]           cbase, cbase_next;
  logic [AW-1:0]           cend, cend_next;
  logic                    pre_f, pre_f_next, post_f, post_f_next;
  logic [CW-1:0]           pre_idx, pre_idx_next, post_idx, post_idx_next;
  logic [AW-1:0]           pre_base, pre_base_next;
  logic [SW-1:0]           pre_size, pre_size_next, post_size, post_size_next;
  logic [AW-1:0]           res_addr, res_addr_next;
  logic [1:0]              res_status, res_status_next;

  // Response register.
  logic                    out_valid, out_valid_next;
  logic [AW-1:0]           out_addr, out_addr_next;
  logic [1:0]              out_status, out_status_next;
  logic                    out_free;

  // Table RAM ports.
  logic                            fr_we_seq, fr_we;
  logic [FI_W-1:0]                 fr_waddr_seq, fr_waddr;
  logic [fla_pkg::FREE_ENTRY_W-1:0] fr_wdata_seq, fr_wdata, fr_rdata;
  logic                            gr_we;
  logic [GI_W-1:0]                 gr_waddr;
  logic [fla_pkg::GRANT_ENTRY_W-1:0] gr_wdata, gr_rdata;

  logic [AW-1:0] fr_base, g_addr;
  logic [SW-1:0] fr_size;
  logic [NW-1:0] g_size;
  logic [OW-1:0] g_offs;

  // Scan control.
  logic cnt_lt_free, cnt_lt_grant, first_pol;
  logic fit_issue, fit_done, g_issue, g_done, n_issue, n_done;
  logic fs_done, gs_done, remove_pick;

  // Configuration side.
  logic                       cfg_reload;
  logic [fla_pkg::POOL_W-1:0] cfg_size_clamp;
  logic [AW-1:0]              reload_base;
  logic [fla_pkg::POOL_W-1:0] reload_size;

  assign fr_base = fr_rdata[fla_pkg::FREE_ENTRY_W-1 -: AW];
  assign fr_size = fr_rdata[SW-1:0];
  assign g_addr  = gr_rdata[fla_pkg::GRANT_ENTRY_W-1 -: AW];
  assign g_size  = gr_rdata[NW+OW-1:OW];
  assign g_offs  = gr_rdata[OW-1:0];

  assign cnt_lt_free  = cnt < CW'(free_count);
  assign cnt_lt_grant = cnt < CW'(grant_count);
  assign first_pol    = !(fit_policy inside {fla_pkg::POL_BEST, fla_pkg::POL_WORST});

  // First fit stops issuing reads at the first hit; a read already in flight is ignored.
  assign fit_issue = cnt_lt_free && !(found && first_pol);
  assign fit_done  = !fit_issue && !ev_valid;
  assign g_issue   = cnt_lt_grant && !found;
  assign g_done    = !g_issue && !ev_valid;
  assign n_issue   = cnt_lt_free && !(pre_f && post_f);
  assign n_done    = !n_issue && !ev_valid;
  assign fs_done   = !cnt_lt_free && !ev_valid;
  assign gs_done   = !cnt_lt_grant && !ev_valid;
  assign remove_pick = (pick_size == SW'(need));

  assign out_free = !out_valid || rsp.ready;

  assign req.ready           = (state == fla_pkg::S_IDLE);
  assign rsp.valid           = out_valid;
  assign rsp.granted_address = out_addr;
  assign rsp.status          = out_status;

  // A pool register write reloads entry zero with the new pool.
  assign cfg_reload = cfg_we && ((cfg_index == fla_pkg::CFG_POOL_BASE) ||
                                 (cfg_index == fla_pkg::CFG_POOL_SIZE));
  assign cfg_size_clamp = (cfg_data[fla_pkg::POOL_W-1:0] > fla_pkg::POOL_W'(fla_pkg::POOL_MAX))
                        ? fla_pkg::POOL_W'(fla_pkg::POOL_MAX) : cfg_data[fla_pkg::POOL_W-1:0];
  assign reload_base = (cfg_index == fla_pkg::CFG_POOL_BASE) ? cfg_data[AW-1:0] : pool_base;
  assign reload_size = (cfg_index == fla_pkg::CFG_POOL_SIZE) ? cfg_size_clamp : pool_size;

  // Reset and reloads take the free table write port ahead of the sequencer.
  always_comb begin
    if (rst) begin
      fr_we    = 1'b1;
      fr_waddr = '0;
      fr_wdata = {AW'(0), SW'(fla_pkg::POOL_SIZE_RST)};
    end else if (cfg_reload) begin
      fr_we    = 1'b1;
      fr_waddr = '0;
      fr_wdata = {reload_base, SW'(reload_size)};
    end else begin
      fr_we    = fr_we_seq;
      fr_waddr = fr_waddr_seq;
      fr_wdata = fr_wdata_seq;
    end
  end

  fla_ram #(.WIDTH(fla_pkg::FREE_ENTRY_W), .DEPTH(FREE_ENTRIES)) u_free_ram (
    .clk   (clk),
    .we    (fr_we),
    .waddr (fr_waddr),
    .wdata (fr_wdata),
    .raddr (cnt[FI_W-1:0]),
    .rdata (fr_rdata)
  );

  fla_ram #(.WIDTH(fla_pkg::GRANT_ENTRY_W), .DEPTH(GRANT_ENTRIES)) u_grant_ram (
    .clk   (clk),
    .we    (gr_we),
    .waddr (gr_waddr),
    .wdata (gr_wdata),
    .raddr (cnt[GI_W-1:0]),
    .rdata (gr_rdata)
  );

  // Sequencer next state.
  always_comb begin
    state_next = state;
    case (state)
      fla_pkg::S_IDLE: begin
        if (req.valid) begin
          if (req.req_type == fla_pkg::REQ_FREE) begin
            state_next = fla_pkg::S_GSCAN;
          end else if (grant_count >= GC_W'(GRANT_ENTRIES)) begin
            state_next = fla_pkg::S_OUT;
          end else begin
            state_next = fla_pkg::S_NEED;
          end
        end
      end
      fla_pkg::S_NEED:  state_next = fla_pkg::S_FIT;
      fla_pkg::S_FIT: begin
        if (fit_done) begin
          state_next = found ? fla_pkg::S_ALIGN : fla_pkg::S_OUT;
        end
      end
      fla_pkg::S_ALIGN: state_next = fla_pkg::S_COMMIT;
      fla_pkg::S_COMMIT: begin
        state_next = remove_pick ? fla_pkg::S_FSHIFT : fla_pkg::S_OUT;
      end
      fla_pkg::S_FSHIFT: begin
        if (fs_done) begin
          state_next = fla_pkg::S_OUT;
        end
      end
      fla_pkg::S_GSCAN: begin
        if (g_done) begin
          state_next = found ? fla_pkg::S_GPREP : fla_pkg::S_OUT;
        end
      end
      fla_pkg::S_GPREP: state_next = fla_pkg::S_GEND;
      fla_pkg::S_GEND:  state_next = fla_pkg::S_GSHIFT;
      fla_pkg::S_GSHIFT: begin
        if (gs_done) begin
          state_next = fla_pkg::S_NSCAN;
        end
      end
      fla_pkg::S_NSCAN: begin
        if (n_done) begin
          state_next = fla_pkg::S_MERGE;
        end
      end
      fla_pkg::S_MERGE: begin
        state_next = (pre_f && post_f) ? fla_pkg::S_FSHIFT : fla_pkg::S_OUT;
      end
      fla_pkg::S_OUT: begin
        if (out_free) begin
          state_next = fla_pkg::S_IDLE;
        end
      end
      default: state_next = fla_pkg::S_IDLE;
    endcase
  end

  // Sequencer datapath and table writes.
  always_comb begin
    logic [LW-1:0]  al;
    logic [NW:0]    rounded;
    logic [OW-1:0]  mis;
    logic [AW-1:0]  fend;

    al      = '0;
    rounded = '0;
    mis     = '0;
    fend    = '0;

    free_count_next  = free_count;
    grant_count_next = grant_count;
    r_addr_next      = r_addr;
    r_size_next      = r_size;
    lg_next          = lg;
    align_next       = align;
    need_next        = need;
    offs_next        = offs;
    cnt_next         = cnt;
    ev_valid_next    = 1'b0;
    ev_idx_next      = cnt;
    found_next       = found;
    pick_idx_next    = pick_idx;
    pick_base_next   = pick_base;
    pick_size_next   = pick_size;
    cbase_next       = cbase;
    cend_next        = cend;
    pre_f_next       = pre_f;
    post_f_next      = post_f;
    pre_idx_next     = pre_idx;
    post_idx_next    = post_idx;
    pre_base_next    = pre_base;
    pre_size_next    = pre_size;
    post_size_next   = post_size;
    res_addr_next    = res_addr;
    res_status_next  = res_status;
    out_valid_next   = out_valid && !rsp.ready;
    out_addr_next    = out_addr;
    out_status_next  = out_status;

    fr_we_seq    = 1'b0;
    fr_waddr_seq = cnt[FI_W-1:0];
    fr_wdata_seq = fr_rdata;
    gr_we        = 1'b0;
    gr_waddr     = grant_count[GI_W-1:0];
    gr_wdata     = gr_rdata;

    case (state)
      fla_pkg::S_IDLE: begin
        if (req.valid) begin
          r_addr_next     = req.free_address;
          r_size_next     = req.alloc_size;
          cnt_next        = '0;
          found_next      = 1'b0;
          pre_f_next      = 1'b0;
          post_f_next     = 1'b0;
          res_addr_next   = '0;
          res_status_next = fla_pkg::STAT_FULL;
          if (req.align_code == 4'd0) begin
            lg_next = (dalign > 4'(fla_pkg::MAX_ALIGN_LG)) ? 4'(fla_pkg::MAX_ALIGN_LG) : dalign;
          end else if (req.align_code > 4'(fla_pkg::MAX_CODE)) begin
            lg_next = 4'(fla_pkg::MAX_CODE - 1);
          end else begin
            lg_next = req.align_code - 4'd1;
          end
        end
      end

      fla_pkg::S_NEED: begin
        // Round up to the alignment, then add one alignment of slack and the guard.
        al         = LW'(1) << lg;
        rounded    = ((NW+1)'(r_size) + (NW+1)'(al) - (NW+1)'(1)) & ~((NW+1)'(al) - (NW+1)'(1));
        need_next  = NW'(rounded + (NW+1)'(al) + (NW+1)'(fla_pkg::GUARD_BYTES));
        align_next = al;
      end

      fla_pkg::S_FIT: begin
        if (fit_issue) begin
          cnt_next      = cnt + CW'(1);
          ev_valid_next = 1'b1;
        end
        if (ev_valid && !(found && first_pol) && (fr_size >= SW'(need))) begin
          if (!found || ((fit_policy == fla_pkg::POL_BEST) && (pick_size > fr_size)) ||
              ((fit_policy == fla_pkg::POL_WORST) && (pick_size < fr_size))) begin
            found_next     = 1'b1;
            pick_idx_next  = ev_idx;
            pick_base_next = fr_base;
            pick_size_next = fr_size;
          end
        end
        if (fit_done && !found) begin
          res_status_next = fla_pkg::STAT_NOFIT;
        end
      end

      fla_pkg::S_ALIGN: begin
        mis = pick_base[OW-1:0] & OW'(align - LW'(1));
        if (mis != '0) begin
          offs_next = OW'(align - LW'(mis));
        end else begin
          offs_next = '0;
          need_next = need - NW'(align);
        end
      end

      fla_pkg::S_COMMIT: begin
        gr_we            = 1'b1;
        gr_waddr         = grant_count[GI_W-1:0];
        gr_wdata         = {pick_base + AW'(offs), need, offs};
        grant_count_next = grant_count + GC_W'(1);
        res_addr_next    = pick_base + AW'(offs);
        res_status_next  = fla_pkg::STAT_OK;
        if (remove_pick) begin
          cnt_next = pick_idx + CW'(1);
        end else begin
          fr_we_seq    = 1'b1;
          fr_waddr_seq = pick_idx[FI_W-1:0];
          fr_wdata_seq = {pick_base + AW'(need), pick_size - SW'(need)};
        end
      end

      fla_pkg::S_FSHIFT: begin
        // Each entry after the removed one moves down by one place.
        if (cnt_lt_free) begin
          cnt_next      = cnt + CW'(1);
          ev_valid_next = 1'b1;
        end
        if (ev_valid) begin
          fr_we_seq    = 1'b1;
          fr_waddr_seq = FI_W'(ev_idx - CW'(1));
          fr_wdata_seq = fr_rdata;
        end
        if (fs_done) begin
          free_count_next = free_count - FC_W'(1);
        end
      end

      fla_pkg::S_GSCAN: begin
        if (g_issue) begin
          cnt_next      = cnt + CW'(1);
          ev_valid_next = 1'b1;
        end
        if (ev_valid && !found && (g_addr == r_addr)) begin
          found_next     = 1'b1;
          pick_idx_next  = ev_idx;
          pick_base_next = g_addr;
          pick_size_next = SW'(g_size);
          offs_next      = g_offs;
        end
        if (g_done && !found) begin
          res_status_next = fla_pkg::STAT_UNKNOWN;
        end
      end

      fla_pkg::S_GPREP: begin
        cbase_next = pick_base - AW'(offs);
      end

      fla_pkg::S_GEND: begin
        cend_next = cbase + AW'(pick_size);
        cnt_next  = pick_idx + CW'(1);
      end

      fla_pkg::S_GSHIFT: begin
        if (cnt_lt_grant) begin
          cnt_next      = cnt + CW'(1);
          ev_valid_next = 1'b1;
        end
        if (ev_valid) begin
          gr_we    = 1'b1;
          gr_waddr = GI_W'(ev_idx - CW'(1));
          gr_wdata = gr_rdata;
        end
        if (gs_done) begin
          grant_count_next = grant_count - GC_W'(1);
          cnt_next         = '0;
        end
      end

      fla_pkg::S_NSCAN: begin
        // A later neighbor replaces an earlier one until both sides are known.
        if (n_issue) begin
          cnt_next      = cnt + CW'(1);
          ev_valid_next = 1'b1;
        end
        fend = fr_base + AW'(fr_size);
        if (ev_valid && !(pre_f && post_f)) begin
          if (fend == cbase) begin
            pre_f_next    = 1'b1;
            pre_idx_next  = ev_idx;
            pre_base_next = fr_base;
            pre_size_next = fr_size;
          end else if (fr_base == cend) begin
            post_f_next    = 1'b1;
            post_idx_next  = ev_idx;
            post_size_next = fr_size;
          end
        end
      end

      fla_pkg::S_MERGE: begin
        res_addr_next   = '0;
        res_status_next = fla_pkg::STAT_OK;
        if (pre_f && post_f) begin
          fr_we_seq    = 1'b1;
          fr_waddr_seq = pre_idx[FI_W-1:0];
          fr_wdata_seq = {pre_base, pre_size + pick_size + post_size};
          cnt_next     = post_idx + CW'(1);
        end else if (pre_f) begin
          fr_we_seq    = 1'b1;
          fr_waddr_seq = pre_idx[FI_W-1:0];
          fr_wdata_seq = {pre_base, pre_size + pick_size};
        end else if (post_f) begin
          fr_we_seq    = 1'b1;
          fr_waddr_seq = post_idx[FI_W-1:0];
          fr_wdata_seq = {cbase, post_size + pick_size};
        end else if (free_count < FC_W'(FREE_ENTRIES)) begin
          fr_we_seq       = 1'b1;
          fr_waddr_seq    = free_count[FI_W-1:0];
          fr_wdata_seq    = {cbase, pick_size};
          free_count_next = free_count + FC_W'(1);
        end
      end

      fla_pkg::S_OUT: begin
        if (out_free) begin
          out_valid_next  = 1'b1;
          out_addr_next   = res_addr;
          out_status_next = res_status;
        end
      end

      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= fla_pkg::S_IDLE;
      fit_policy  <= fla_pkg::POL_FIRST;
      dalign      <= 4'(fla_pkg::DALIGN_RST);
      pool_base   <= '0;
      pool_size   <= fla_pkg::POOL_W'(fla_pkg::POOL_SIZE_RST);
      free_count  <= FC_W'(1);
      grant_count <= '0;
      ev_valid    <= 1'b0;
      found       <= 1'b0;
      pre_f       <= 1'b0;
      post_f      <= 1'b0;
      out_valid   <= 1'b0;
      cnt         <= '0;
    end else begin
      state       <= state_next;
      grant_count <= grant_count_next;
      ev_valid    <= ev_valid_next;
      found       <= found_next;
      pre_f       <= pre_f_next;
      post_f      <= post_f_next;
      out_valid   <= out_valid_next;
      cnt         <= cnt_next;
      // A pool reload leaves one entry, or none for an empty pool.
      if (cfg_reload) begin
        free_count <= FC_W'(reload_size != '0);
      end else begin
        free_count <= free_count_next;
      end
      if (cfg_we) begin
        case (cfg_index)
          fla_pkg::CFG_FIT_POLICY: fit_policy <= cfg_data[1:0];
          fla_pkg::CFG_DALIGN:     dalign     <= cfg_data[3:0];
          fla_pkg::CFG_POOL_BASE:  pool_base  <= cfg_data[AW-1:0];
          fla_pkg::CFG_POOL_SIZE:  pool_size  <= cfg_size_clamp;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    r_addr     <= r_addr_next;
    r_size     <= r_size_next;
    lg         <= lg_next;
    align      <= align_next;
    need       <= need_next;
    offs       <= offs_next;
    ev_idx     <= ev_idx_next;
    pick_idx   <= pick_idx_next;
    pick_base  <= pick_base_next;
    pick_size  <= pick_size_next;
    cbase      <= cbase_next;
    cend       <= cend_next;
    pre_idx    <= pre_idx_next;
    post_idx   <= post_idx_next;
    pre_base   <= pre_base_next;
    pre_size   <= pre_size_next;
    post_size  <= post_size_next;
    res_addr   <= res_addr_next;
    res_status <= res_status_next;
    out_addr   <= out_addr_next;
    out_status <= out_status_next;
  end

endmodule

/* test/tb_chan_if.sv */
// Testbench package: the response record that the checker predicts and compares.
package tb_alloc_pkg;

  typedef struct packed {
    logic [31:0] granted_address;
    logic [1:0]  status;
  } alloc_rsp_t;
endpackage

/* test/tb_alloc_checker.sv */
// Checker: watches both channels, predicts each response and compares it.
module tb_alloc_checker (
  input  logic                          clk,
  input  logic                          rst,
  fla_req_if                            req,
  fla_rsp_if                            rsp,
  input  logic                          cfg_we,
  input  logic [fla_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fla_pkg::CFG_W-1:0]     cfg_data,
  output int                            fail_count,
  output int                            pending,
  output int                            rsp_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NFREE  = fla_pkg::FREE_ENTRIES_DEF;
  localparam int NGRANT = fla_pkg::GRANT_ENTRIES_DEF;

  logic [1:0]  policy;
  logic [3:0]  dalign;
  logic [31:0] pbase;
  logic [24:0] psize;

  logic [31:0] fbase [NFREE];
  logic [31:0] fsize [NFREE];
  int          fcnt;
  logic [31:0] gaddr [NGRANT];
  logic [31:0] gsize [NGRANT];
  logic [31:0] goffs [NGRANT];
  int          gcnt;

  tb_alloc_pkg::alloc_rsp_t expected_q[$];

  function automatic void reload();
    fbase[0] = pbase;
    fsize[0] = {7'd0, psize};
    fcnt = (psize != 0) ? 1 : 0;
  endfunction

  function automatic void drop_free(int idx);
    for (int i = idx; i + 1 < fcnt; i++) begin
      fbase[i] = fbase[i+1];
      fsize[i] = fsize[i+1];
    end
    fcnt--;
  endfunction

  function automatic tb_alloc_pkg::alloc_rsp_t predict_alloc(logic [23:0] sz,
                                                             logic [3:0] code);
    tb_alloc_pkg::alloc_rsp_t r;
    int lg, pick;
    logic [31:0] align, need, b, offs;
    r = '0;
    if (gcnt >= NGRANT) begin
      r.status = fla_pkg::STAT_FULL;
      return r;
    end
    if (code == 0) lg = (dalign > fla_pkg::MAX_ALIGN_LG) ? fla_pkg::MAX_ALIGN_LG : dalign;
    else lg = ((code > fla_pkg::MAX_CODE) ? fla_pkg::MAX_CODE : code) - 1;
    align = 32'd1 << lg;
    need = ((sz + align - 1) & ~(align - 1)) + align + fla_pkg::GUARD_BYTES;
    pick = -1;
    for (int i = 0; i < fcnt; i++) begin
      if (fsize[i] < need) continue;
      if (pick < 0) begin
        pick = i;
        if (policy != fla_pkg::POL_BEST && policy != fla_pkg::POL_WORST) break;
      end else if (policy == fla_pkg::POL_BEST && fsize[pick] > fsize[i]) pick = i;
      else if (policy == fla_pkg::POL_WORST && fsize[pick] < fsize[i]) pick = i;
    end
    if (pick < 0) begin
      r.status = fla_pkg::STAT_NOFIT;
      return r;
    end
    b = fbase[pick];
    if ((b & (align - 1)) != 0) offs = align - (b & (align - 1));
    else begin
      offs = 0;
      need -= align;
    end
    if (fsize[pick] == need) drop_free(pick);
    else begin
      fbase[pick] = b + need;
      fsize[pick] -= need;
    end
    gaddr[gcnt] = b + offs;
    gsize[gcnt] = need;
    goffs[gcnt] = offs;
    gcnt++;
    r.granted_address = b + offs;
    r.status = fla_pkg::STAT_OK;
    return r;
  endfunction

  function automatic tb_alloc_pkg::alloc_rsp_t predict_free(logic [31:0] a);
    tb_alloc_pkg::alloc_rsp_t r;
    int g, lo, hi;
    logic [31:0] cb, cs, ce;
    r = '0;
    lo = -1;
    hi = -1;
    for (g = 0; g < gcnt; g++) if (gaddr[g] == a) break;
    if (g >= gcnt) begin
      r.status = fla_pkg::STAT_UNKNOWN;
      return r;
    end
    cb = gaddr[g] - goffs[g];
    cs = gsize[g];
    ce = cb + cs;
    for (int i = g; i + 1 < gcnt; i++) begin
      gaddr[i] = gaddr[i+1];
      gsize[i] = gsize[i+1];
      goffs[i] = goffs[i+1];
    end
    gcnt--;
    // Neighbor scan in table order; later hits replace earlier ones.
    for (int i = 0; i < fcnt; i++) begin
      if (fbase[i] + fsize[i] == cb) begin
        lo = i;
        if (hi >= 0) break;
      end else if (fbase[i] == ce) begin
        hi = i;
        if (lo >= 0) break;
      end
    end
    if (lo >= 0 && hi >= 0) begin
      fsize[lo] += cs + fsize[hi];
      drop_free(hi);
    end else if (lo >= 0) fsize[lo] += cs;
    else if (hi >= 0) begin
      fbase[hi] = cb;
      fsize[hi] += cs;
    end else if (fcnt < NFREE) begin
      fbase[fcnt] = cb;
      fsize[fcnt] = cs;
      fcnt++;
    end
    r.status = fla_pkg::STAT_OK;
    return r;
  endfunction

  always @(posedge clk) begin
    tb_alloc_pkg::alloc_rsp_t e;
    if (rst) begin
      policy = fla_pkg::POL_FIRST;
      dalign = 4'(fla_pkg::DALIGN_RST);
      pbase = '0;
      psize = 25'(fla_pkg::POOL_SIZE_RST);
      gcnt = 0;
      reload();
      fail_count <= 0;
      rsp_seen <= 0;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          fla_pkg::CFG_FIT_POLICY: policy = cfg_data[1:0];
          fla_pkg::CFG_DALIGN: dalign = cfg_data[3:0];
          fla_pkg::CFG_POOL_BASE: begin
            pbase = cfg_data;
            reload();
          end
          fla_pkg::CFG_POOL_SIZE: begin
            psize = (cfg_data[24:0] > 25'(fla_pkg::POOL_MAX)) ? 25'(fla_pkg::POOL_MAX)
                                                                : cfg_data[24:0];
            reload();
          end
          default: begin
          end
        endcase
      end
      if (req.valid && req.ready) begin
        if (req.req_type == fla_pkg::REQ_ALLOC)
          expected_q.push_back(predict_alloc(req.alloc_size, req.align_code));
        else
          expected_q.push_back(predict_free(req.free_address));
      end
      if (rsp.valid && rsp.ready) begin
        rsp_seen <= rsp_seen + 1;
        if (expected_q.size() == 0) begin
          if (fail_count < 10) $display("ERROR: response beat with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          e = expected_q.pop_front();
          if (e.granted_address !== rsp.granted_address || e.status !== rsp.status) begin
            if (fail_count < 10)
              $display("ERROR: expected addr %h status %0d, got addr %h status %0d",
                       e.granted_address, e.status, rsp.granted_address, rsp.status);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending <= expected_q.size();
  end
endmodule

/* test/tb.sv */
// Top of the testbench: clock, reset, stimulus phases and the verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                          cfg_we = 1'b0;
  logic [fla_pkg::CFG_IDX_W-1:0] cfg_index = fla_pkg::CFG_FIT_POLICY;
  logic [fla_pkg::CFG_W-1:0]     cfg_data = '0;

  fla_req_if req ();
  fla_rsp_if rsp ();

  int fail_count, pending, rsp_seen;
  int send_idle_pct = 0;   // Chance in percent that the sender idles a cycle.
  int sink_stall_pct = 0;  // Chance in percent that the receiver stalls a cycle.
  int hold_cycles = 0;     // Long receiver hold-off, counted down by its own process.
  int cycle_count = 0;
  int n_alloc = 0, n_free = 0;
  logic [31:0] granted_q[$];

  free_list_fit_allocator dut (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  tb_alloc_checker chk (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending), .rsp_seen(rsp_seen)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    req.valid = 1'b0;
    req.req_type = fla_pkg::REQ_ALLOC;
    req.alloc_size = '0;
    req.align_code = '0;
    req.free_address = '0;
    rsp.ready = 1'b0;
  end

  // The timeout, set far above the length of any correct run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 900000) begin
      $display("simulation failed");
      $finish;
    end
  end

  // The receiver decides ready once per falling edge, and honors a long hold-off.
  always @(negedge clk) begin
    if (rst) rsp.ready <= 1'b0;
    else if (hold_cycles > 0) begin
      rsp.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else rsp.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Collect granted addresses so that frees mostly hit live grants.
  always @(posedge clk)
    if (!rst && rsp.valid && rsp.ready && rsp.status == fla_pkg::STAT_OK &&
        rsp.granted_address != 0)
      granted_q.push_back(rsp.granted_address);

  task automatic write_reg(input logic [fla_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Offers one beat at a falling edge and holds it until it is accepted.
  task automatic send_beat(input logic rt, input logic [23:0] sz, input logic [3:0] code,
                           input logic [31:0] addr);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    req.valid = 1'b1;
    req.req_type = rt;
    req.alloc_size = sz;
    req.align_code = code;
    req.free_address = addr;
    do @(posedge clk); while (!req.ready);
    @(negedge clk);
    req.valid = 1'b0;
    if (rt == fla_pkg::REQ_ALLOC) n_alloc++;
    else n_free++;
  endtask

  // Waits until every expected response has come, then lets the block settle.
  task automatic drain();
    do @(negedge clk); while (pending != 0 || req.valid);
    repeat (100) @(negedge clk);
  endtask

  // A random request: mostly small allocations and frees of live grants, with
  // some huge sizes, odd alignments and unknown addresses mixed in.
  task automatic random_beat();
    int k, pick;
    logic [31:0] a;
    k = $urandom_range(99);
    if (k < 50) begin
      send_beat(fla_pkg::REQ_ALLOC, (k < 3) ? 24'($urandom) : 24'($urandom_range(600)),
                4'($urandom_range(15)), $urandom);
    end else if (k < 92 && granted_q.size() > 0) begin
      pick = $urandom_range(granted_q.size() - 1);
      a = granted_q[pick];
      granted_q.delete(pick);
      send_beat(fla_pkg::REQ_FREE, 24'($urandom), 4'($urandom), a);
    end else begin
      send_beat(fla_pkg::REQ_FREE, 24'($urandom), 4'($urandom), $urandom);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part: extremes of size and alignment, every status, zero size.
    send_beat(fla_pkg::REQ_ALLOC, 24'd0, 4'd0, 32'd0);
    send_beat(fla_pkg::REQ_ALLOC, 24'hFFFFFF, 4'd1, 32'd0);
    send_beat(fla_pkg::REQ_ALLOC, 24'd1, 4'd13, 32'd0);
    send_beat(fla_pkg::REQ_ALLOC, 24'd7, 4'd15, 32'd0);
    send_beat(fla_pkg::REQ_ALLOC, 24'd100, 4'd1, 32'd0);
    send_beat(fla_pkg::REQ_FREE, 24'd0, 4'd0, 32'hFFFFFFFF);
    send_beat(fla_pkg::REQ_FREE, 24'd0, 4'd0, 32'h0000_0000);
    for (int i = 0; i < 18; i++) send_beat(fla_pkg::REQ_ALLOC, 24'd8, 4'd3, 32'd0);
    drain();
    granted_q.delete();

    // Phases: policies, alignments and pools, with four idling patterns in turn.
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(fla_pkg::CFG_FIT_POLICY, ph % 4);
      write_reg(fla_pkg::CFG_DALIGN, (ph == 3) ? 15 : $urandom_range(12));
      case (ph)
        0: write_reg(fla_pkg::CFG_POOL_BASE, 32'hFFFF_F000);
        1: write_reg(fla_pkg::CFG_POOL_BASE, 32'h0);
        7: write_reg(fla_pkg::CFG_POOL_BASE, $urandom);
        default: write_reg(fla_pkg::CFG_POOL_BASE, 32'h1000_0000 + $urandom_range(4095));
      endcase
      case (ph)
        2: write_reg(fla_pkg::CFG_POOL_SIZE, 0);
        4: write_reg(fla_pkg::CFG_POOL_SIZE, 32'h01FF_FFFF);
        5: write_reg(fla_pkg::CFG_POOL_SIZE, fla_pkg::POOL_MAX);
        default: write_reg(fla_pkg::CFG_POOL_SIZE, $urandom_range(256, 8192));
      endcase
      send_idle_pct  = (ph % 4 == 1 || ph % 4 == 3) ? ((ph % 4 == 3) ? 10 : 77) : 0;
      sink_stall_pct = (ph % 4 == 2 || ph % 4 == 3) ? ((ph % 4 == 3) ? 10 : 77) : 0;
      if (ph == 4) hold_cycles = 400;
      for (int i = 0; i < 78; i++) random_beat();
      drain();
      granted_q.delete();
    end
    send_idle_pct = 0;
    sink_stall_pct = 0;
    drain();

    $display("Covered %0d allocates and %0d frees, %0d responses checked,", n_alloc, n_free,
             rsp_seen);
    $display("over all fit policies, alignment extremes and pool settings.");
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule

/* sim.f */
sv/fla_pkg.sv
sv/fla_req_if.sv
sv/fla_rsp_if.sv
sv/fla_ram.sv
sv/free_list_fit_allocator.sv
test/tb_chan_if.sv
test/tb_alloc_checker.sv
test/tb.sv
